>>> rtl/sccb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccb_pkg
// Shared types and constants for the SCCB register master.
// ----------------------------------------------------------------------------
package sccb_pkg;

	localparam int DELAY_COUNT_WIDTH = 16;
	localparam int HALF_W            = 16;
	// compare width for slot timing, one above the wider of counter and half period
	localparam int CMP_W = ((DELAY_COUNT_WIDTH > HALF_W) ? DELAY_COUNT_WIDTH : HALF_W) + 1;

	localparam logic [7:0] MSB_MASK = 8'h80;
	localparam logic [7:0] READ_BIT = 8'h01;

	localparam logic [7:0]  DEV_ID_RESET      = 8'h60;
	localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;

	typedef enum logic {
		CFG_DEVICE_ID   = 1'b0,
		CFG_HALF_PERIOD = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_READ  = 1'b1
	} func_t;

	typedef enum logic [4:0] {
		PH_IDLE = 5'd0,
		PH_S1   = 5'd1,
		PH_S2   = 5'd2,
		PH_WLO  = 5'd3,
		PH_WHI  = 5'd4,
		PH_ALO  = 5'd5,
		PH_AHI  = 5'd6,
		PH_P1   = 5'd7,
		PH_P2   = 5'd8,
		PH_P3   = 5'd9,
		PH_GAP  = 5'd10,
		PH_RLO  = 5'd11,
		PH_RHI  = 5'd12,
		PH_N1   = 5'd13,
		PH_N2   = 5'd14,
		PH_N3   = 5'd15
	} phase_t;

	typedef struct packed {
		logic       start_request;
		logic       func;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_sample;
	} req_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_value;
		logic       sda_enable;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       nack_error;
	} res_t;

endpackage

>>> rtl/sccb_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccb_req_if
// Valid/ready channel carrying one tick of request and bus input.
// ----------------------------------------------------------------------------
interface sccb_req_if
	import sccb_pkg::*;
;
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/sccb_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccb_res_if
// Valid/ready channel carrying one tick of bus drive and status.
// ----------------------------------------------------------------------------
interface sccb_res_if
	import sccb_pkg::*;
;
	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/sccb_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccb_core
// Bus sequencer: slot timer, phase machine and shift registers. Output is
// decoded from the current state; the state advances on each step.
// ----------------------------------------------------------------------------
module sccb_core
	import sccb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  req_t              req,
	input  logic [7:0]        dev_id,
	input  logic [HALF_W-1:0] half_period,
	output res_t              res
);

	phase_t                       phase_q, phase_d;
	logic [1:0]                   byte_q, byte_d;
	logic [2:0]                   bit_q, bit_d;
	logic [7:0]                   tx_q, tx_d;
	logic [7:0]                   rx_q, rx_d;
	logic [DELAY_COUNT_WIDTH-1:0] dly_q, dly_d;
	logic                         func_q, func_d;
	logic [7:0]                   addr_q, addr_d;
	logic [7:0]                   wdat_q, wdat_d;
	logic                         err_q, err_d;

	logic       busy, last, is_read, done;
	logic       load, tx_bit;
	logic [1:0] load_sel;
	logic [7:0] load_byte;
	logic [CMP_W-1:0] dly_inc, half_ext, max_len, slot_len;

	// slot length: zero runs as one tick, saturates at the counter range
	assign busy     = (phase_q != PH_IDLE);
	assign is_read  = (func_q == FUNC_READ);
	assign dly_inc  = CMP_W'(dly_q) + CMP_W'(1);
	assign half_ext = CMP_W'(half_period);
	assign max_len  = CMP_W'(1) << DELAY_COUNT_WIDTH;
	assign slot_len = (half_period == '0) ? CMP_W'(1) :
		((half_ext > max_len) ? max_len : half_ext);
	assign last     = busy && (dly_inc >= slot_len);
	assign done     = (phase_q == PH_P3) && last && !(is_read && byte_q == 2'd2);
	assign tx_bit   = |(tx_q & MSB_MASK);

	always_comb begin
		case (load_sel)
			2'd0:    load_byte = dev_id;
			2'd1:    load_byte = addr_q;
			2'd2:    load_byte = wdat_q;
			default: load_byte = dev_id | READ_BIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			byte_q  <= '0;
			bit_q   <= '0;
			tx_q    <= '0;
			rx_q    <= '0;
			dly_q   <= '0;
			func_q  <= 1'b0;
			addr_q  <= '0;
			wdat_q  <= '0;
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			byte_q  <= byte_d;
			bit_q   <= bit_d;
			tx_q    <= tx_d;
			rx_q    <= rx_d;
			dly_q   <= dly_d;
			func_q  <= func_d;
			addr_q  <= addr_d;
			wdat_q  <= wdat_d;
			err_q   <= err_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		byte_d   = byte_q;
		bit_d    = bit_q;
		tx_d     = tx_q;
		rx_d     = rx_q;
		dly_d    = dly_q;
		func_d   = func_q;
		addr_d   = addr_q;
		wdat_d   = wdat_q;
		err_d    = err_q;
		load     = 1'b0;
		load_sel = byte_q;

		res.scl_level  = 1'b1;
		res.sda_value  = 1'b1;
		res.sda_enable = 1'b1;
		res.busy_res   = busy;
		res.done_res   = done;
		res.read_byte  = rx_q;
		res.nack_error = err_q;

		case (phase_q)
			PH_S2:  res.sda_value = 1'b0;
			PH_WLO: begin
				res.scl_level = 1'b0;
				res.sda_value = tx_bit;
			end
			PH_WHI: res.sda_value = tx_bit;
			PH_ALO, PH_RLO: begin
				res.scl_level  = 1'b0;
				res.sda_value  = 1'b0;
				res.sda_enable = 1'b0;
			end
			PH_AHI, PH_RHI: begin
				res.sda_value  = 1'b0;
				res.sda_enable = 1'b0;
			end
			PH_P1: begin
				res.scl_level = 1'b0;
				res.sda_value = 1'b0;
			end
			PH_P2:  res.sda_value = 1'b0;
			PH_N1, PH_N3: res.scl_level = 1'b0;
			default: ;
		endcase

		if (!busy) begin
			if (req.start_request) begin
				func_d  = req.func;
				addr_d  = req.reg_addr;
				wdat_d  = req.write_data;
				byte_d  = 2'd0;
				bit_d   = 3'd0;
				dly_d   = '0;
				phase_d = PH_S1;
				if (req.func == FUNC_WRITE) begin
					err_d = 1'b0;
				end
			end
		end else begin
			if (phase_q == PH_RHI && dly_q == '0) begin
				rx_d = {rx_q[6:0], req.sda_sample};
			end
			if (phase_q == PH_AHI && last && !is_read && req.sda_sample) begin
				err_d = 1'b1;
			end
			if (last) begin
				dly_d = '0;
				case (phase_q)
					PH_S1:  phase_d = PH_S2;
					PH_S2: begin
						load    = 1'b1;
						bit_d   = 3'd0;
						phase_d = PH_WLO;
					end
					PH_WLO: phase_d = PH_WHI;
					PH_WHI: begin
						if (bit_q == 3'd7) begin
							bit_d   = 3'd0;
							phase_d = PH_ALO;
						end else begin
							bit_d   = bit_q + 3'd1;
							tx_d    = {tx_q[6:0], 1'b0};
							phase_d = PH_WLO;
						end
					end
					PH_ALO: phase_d = PH_AHI;
					PH_AHI: begin
						if (!is_read) begin
							if (byte_q < 2'd2) begin
								byte_d   = byte_q + 2'd1;
								load_sel = byte_q + 2'd1;
								load     = 1'b1;
								phase_d  = PH_WLO;
							end else begin
								phase_d = PH_P1;
							end
						end else if (byte_q == 2'd0) begin
							byte_d   = 2'd1;
							load_sel = 2'd1;
							load     = 1'b1;
							phase_d  = PH_WLO;
						end else if (byte_q == 2'd1) begin
							byte_d  = 2'd2;
							phase_d = PH_P1;
						end else begin
							bit_d   = 3'd0;
							phase_d = PH_RLO;
						end
					end
					PH_P1:  phase_d = PH_P2;
					PH_P2:  phase_d = PH_P3;
					PH_P3:  phase_d = (is_read && byte_q == 2'd2) ? PH_GAP : PH_IDLE;
					PH_GAP: begin
						byte_d  = 2'd3;
						phase_d = PH_S1;
					end
					PH_RLO: phase_d = PH_RHI;
					PH_RHI: begin
						if (bit_q == 3'd7) begin
							bit_d   = 3'd0;
							phase_d = PH_N1;
						end else begin
							bit_d   = bit_q + 3'd1;
							phase_d = PH_RLO;
						end
					end
					PH_N1:  phase_d = PH_N2;
					PH_N2:  phase_d = PH_N3;
					PH_N3:  phase_d = PH_P1;
					default: phase_d = PH_IDLE;
				endcase
				if (load) begin
					tx_d = load_byte;
				end
			end else begin
				dly_d = dly_inc[DELAY_COUNT_WIDTH-1:0];
			end
		end
	end

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && done |=> phase_q == PH_IDLE)
		else $error("done not followed by idle");

	a_gap_to_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_GAP && last |=> phase_q == PH_S1 && byte_q == 2'd3)
		else $error("gap did not restart with read id");

	a_read_keeps_error: assert property (@(posedge clk) disable iff (!arst_n)
		step && busy && is_read |=> $stable(err_q))
		else $error("error flag changed during read");

	a_idle_no_progress: assert property (@(posedge clk) disable iff (!arst_n)
		step && !busy && !req.start_request |=> phase_q == PH_IDLE && $stable(rx_q))
		else $error("idle state moved without request");

endmodule

>>> rtl/sccb_register_master_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccb_register_master_top
// SCCB register master: three-phase write, two-phase read, one tick per item.
// ----------------------------------------------------------------------------
// Output: the result of each input transfer is registered in the output register.
// Throughput: one tick per cycle; the output register passes when res.ready is
// high, and the input stalls only while a result waits untaken.
// Reset: async active low; sequencer idle, counters and shifters zero,
// device id 0x60, half period 250 ticks.
// ----------------------------------------------------------------------------
module sccb_register_master_top
	import sccb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	sccb_req_if.sink          req,
	sccb_res_if.source        res,
	input  logic              cfg_we,
	input  cfg_idx_t          cfg_idx,
	input  logic [HALF_W-1:0] cfg_data
);

	logic [7:0]        dev_id_q;
	logic [HALF_W-1:0] half_q;
	logic              out_valid_q;
	res_t              res_q;
	res_t              core_res;
	logic              step;

	assign req.ready = !out_valid_q || res.ready;
	assign step      = req.valid && req.ready;
	assign res.valid = out_valid_q;
	assign res.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_id_q <= DEV_ID_RESET;
			half_q   <= HALF_PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DEVICE_ID:   dev_id_q <= cfg_data[7:0];
				CFG_HALF_PERIOD: half_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= core_res;
		end
	end

	sccb_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.req         (req.data),
		.dev_id      (dev_id_q),
		.half_period (half_q),
		.res         (core_res)
	);

endmodule

>>> test/tb_sccb_register_master_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sccb_register_master_top
// Self-checking bench for the SCCB register master. Bus ticks are fed through
// the request channel with random gaps. A cycle-level model of the sequencer
// predicts SCL/SDA drive, busy, done, read byte and NACK for every tick, and
// the result channel is compared field by field. The bench covers directed
// write and read at extreme settings, random traffic, then the longest slot.
// ----------------------------------------------------------------------------
module tb_sccb_register_master_top;
	import sccb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 4000000;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	cfg_idx_t          cfg_idx;
	logic [HALF_W-1:0] cfg_data;

	sccb_req_if tick_in();
	sccb_res_if tick_out();

	sccb_register_master_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tick_in),
		.res     (tick_out),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data)
	);

	// pending ticks and expected bus results
	req_t tick_q[$];
	res_t bus_exp_q[$];

	// model state
	logic [7:0]  cur_dev;
	logic [15:0] cur_half;
	phase_t      ph;
	logic [1:0]  byte_idx;
	logic [3:0]  bit_idx;
	logic [7:0]  tx_sh;
	logic [7:0]  rx_sh;
	int unsigned dly;
	logic        held_func;
	logic [7:0]  held_reg;
	logic [7:0]  held_data;
	logic        err;

	int unsigned errors;
	int unsigned res_cnt;
	int unsigned cycles;
	int unsigned tx_gap;
	int unsigned rx_gap;
	int unsigned rx_hold;
	int unsigned hold_reqs;
	int unsigned holds_served;
	bit          tx_quiet;
	bit          rx_quiet;
	res_t        drv_want;
	res_t        mon_want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] next_byte(logic [1:0] idx);
		case (idx)
			2'd0:    return cur_dev;
			2'd1:    return held_reg;
			2'd2:    return held_data;
			default: return cur_dev | READ_BIT;
		endcase
	endfunction

	function automatic void predict_bus_tick(input req_t t, output res_t o);
		int unsigned len;
		logic        busy;
		logic        last;
		logic        rd;
		len  = (cur_half == 16'd0) ? 1 : cur_half;
		busy = (ph != PH_IDLE);
		last = busy && (dly + 1 >= len);
		rd   = (held_func == FUNC_READ);
		o = '0;
		o.sda_enable = 1'b1;
		case (ph)
			PH_S1, PH_N2: {o.scl_level, o.sda_value} = 2'b11;
			PH_S2, PH_P2: {o.scl_level, o.sda_value} = 2'b10;
			PH_WLO:       {o.scl_level, o.sda_value} = {1'b0, tx_sh[7]};
			PH_WHI:       {o.scl_level, o.sda_value} = {1'b1, tx_sh[7]};
			PH_ALO, PH_RLO: begin
				{o.scl_level, o.sda_value} = 2'b00;
				o.sda_enable = 1'b0;
			end
			PH_AHI, PH_RHI: begin
				{o.scl_level, o.sda_value} = 2'b10;
				o.sda_enable = 1'b0;
			end
			PH_P1:        {o.scl_level, o.sda_value} = 2'b00;
			PH_N1, PH_N3: {o.scl_level, o.sda_value} = 2'b01;
			default:      {o.scl_level, o.sda_value} = 2'b11;
		endcase
		o.busy_res   = busy;
		o.done_res   = (ph == PH_P3) && last && !(rd && byte_idx == 2'd2);
		o.read_byte  = rx_sh;
		o.nack_error = err;

		if (!busy) begin
			if (t.start_request) begin
				held_func = t.func;
				held_reg  = t.reg_addr;
				held_data = t.write_data;
				byte_idx  = 2'd0;
				bit_idx   = 4'd0;
				dly       = 0;
				if (t.func == FUNC_WRITE)
					err = 1'b0;
				ph = PH_S1;
			end
			return;
		end

		// read bits sample on the first tick of the high slot
		if (ph == PH_RHI && dly == 0)
			rx_sh = {rx_sh[6:0], t.sda_sample};
		// write acks sample on the last tick of the high slot
		if (ph == PH_AHI && last && !rd && t.sda_sample)
			err = 1'b1;

		if (!last) begin
			dly++;
			return;
		end
		dly = 0;
		case (ph)
			PH_S1: ph = PH_S2;
			PH_S2: begin
				tx_sh   = next_byte(byte_idx);
				bit_idx = 4'd0;
				ph      = PH_WLO;
			end
			PH_WLO: ph = PH_WHI;
			PH_WHI: begin
				if (bit_idx >= 4'd7) begin
					bit_idx = 4'd0;
					ph      = PH_ALO;
				end else begin
					bit_idx++;
					tx_sh = tx_sh << 1;
					ph    = PH_WLO;
				end
			end
			PH_ALO: ph = PH_AHI;
			PH_AHI: begin
				if (!rd) begin
					if (byte_idx < 2'd2) begin
						byte_idx++;
						tx_sh = next_byte(byte_idx);
						ph    = PH_WLO;
					end else begin
						ph = PH_P1;
					end
				end else if (byte_idx == 2'd0) begin
					byte_idx = 2'd1;
					tx_sh    = next_byte(byte_idx);
					ph       = PH_WLO;
				end else if (byte_idx == 2'd1) begin
					byte_idx = 2'd2;
					ph       = PH_P1;
				end else begin
					bit_idx = 4'd0;
					ph      = PH_RLO;
				end
			end
			PH_P1: ph = PH_P2;
			PH_P2: ph = PH_P3;
			PH_P3: ph = (rd && byte_idx == 2'd2) ? PH_GAP : PH_IDLE;
			PH_GAP: begin
				byte_idx = 2'd3;
				ph       = PH_S1;
			end
			PH_RLO: ph = PH_RHI;
			PH_RHI: begin
				if (bit_idx >= 4'd7) begin
					bit_idx = 4'd0;
					ph      = PH_N1;
				end else begin
					bit_idx++;
					ph = PH_RLO;
				end
			end
			PH_N1:   ph = PH_N2;
			PH_N2:   ph = PH_N3;
			PH_N3:   ph = PH_P1;
			default: ph = PH_IDLE;
		endcase
	endfunction

	function automatic int unsigned pick_gap(bit quiet);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
		if (errors < 40)
			$display("ERROR transfer %0d: %s got %0h expected %0h", res_cnt, what, got, want);
		errors++;
	endtask

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			tick_in.valid <= 1'b0;
		end else begin
			if (tick_in.valid && tick_in.ready) begin
				predict_bus_tick(tick_in.data, drv_want);
				bus_exp_q.push_back(drv_want);
			end
			if (!tick_in.valid || tick_in.ready) begin
				if (tx_gap != 0) begin
					tick_in.valid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if (tick_q.size() != 0) begin
					tick_in.valid <= 1'b1;
					tick_in.data <= tick_q.pop_front();
					tx_gap <= pick_gap(tx_quiet);
				end else begin
					tick_in.valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (!arst_n) begin
			tick_out.ready <= 1'b0;
		end else if (hold_reqs != holds_served) begin
			tick_out.ready <= 1'b0;
			rx_hold <= 400;
			holds_served <= hold_reqs;
		end else if (rx_hold != 0) begin
			tick_out.ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (rx_gap != 0) begin
			tick_out.ready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else begin
			tick_out.ready <= 1'b1;
			rx_gap <= pick_gap(rx_quiet);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && tick_out.valid && tick_out.ready) begin
			if (bus_exp_q.size() == 0) begin
				flag_mismatch("unexpected transfer", 8'h00, 8'h00);
			end else begin
				mon_want = bus_exp_q.pop_front();
				if (tick_out.data.scl_level !== mon_want.scl_level)
					flag_mismatch("scl_level", 8'(tick_out.data.scl_level),
						8'(mon_want.scl_level));
				if (tick_out.data.sda_value !== mon_want.sda_value)
					flag_mismatch("sda_value", 8'(tick_out.data.sda_value),
						8'(mon_want.sda_value));
				if (tick_out.data.sda_enable !== mon_want.sda_enable)
					flag_mismatch("sda_enable", 8'(tick_out.data.sda_enable),
						8'(mon_want.sda_enable));
				if (tick_out.data.busy_res !== mon_want.busy_res)
					flag_mismatch("busy_res", 8'(tick_out.data.busy_res),
						8'(mon_want.busy_res));
				if (tick_out.data.done_res !== mon_want.done_res)
					flag_mismatch("done_res", 8'(tick_out.data.done_res),
						8'(mon_want.done_res));
				if (tick_out.data.read_byte !== mon_want.read_byte)
					flag_mismatch("read_byte", tick_out.data.read_byte, mon_want.read_byte);
				if (tick_out.data.nack_error !== mon_want.nack_error)
					flag_mismatch("nack_error", 8'(tick_out.data.nack_error),
						8'(mon_want.nack_error));
			end
			res_cnt <= res_cnt + 1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_sccb_register_master_top failed");
			$finish;
		end
	end

	task automatic queue_req(logic go, func_t f, logic [7:0] ra, logic [7:0] wd, logic sda);
		req_t t;
		t.start_request = go;
		t.func          = f;
		t.reg_addr      = ra;
		t.write_data    = wd;
		t.sda_sample    = sda;
		tick_q.push_back(t);
	endtask

	task automatic queue_ticks(int n, int req_pct, int sda_pct);
		req_t t;
		repeat (n) begin
			t.start_request = ($urandom_range(0, 99) < req_pct);
			t.func          = 1'($urandom_range(0, 1));
			t.reg_addr      = 8'($urandom);
			t.write_data    = 8'($urandom);
			t.sda_sample    = ($urandom_range(0, 99) < sda_pct);
			tick_q.push_back(t);
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (tick_q.size() != 0 || tick_in.valid || bus_exp_q.size() != 0);
	endtask

	// run idle ticks until the sequencer is back in idle
	task automatic settle(int sda_pct);
		wait_drained();
		while (ph != PH_IDLE) begin
			queue_ticks(64, 0, sda_pct);
			wait_drained();
		end
	endtask

	task automatic write_cfg(logic [7:0] dev, logic [15:0] half);
		repeat (4) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_DEVICE_ID;
		cfg_data <= {8'h00, dev};
		@(posedge clk);
		cfg_idx  <= CFG_HALF_PERIOD;
		cfg_data <= half;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_dev  = dev;
		cur_half = half;
	endtask

	initial begin
		int       req_pct;
		int       sda_pct;
		int       half;
		logic [7:0] dev;

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_idx         = CFG_DEVICE_ID;
		cfg_data        = '0;
		tick_in.valid   = 1'b0;
		tick_in.data    = '0;
		tick_out.ready  = 1'b0;
		cur_dev   = DEV_ID_RESET;
		cur_half  = HALF_PERIOD_RESET;
		ph        = PH_IDLE;
		byte_idx  = '0;
		bit_idx   = '0;
		tx_sh     = '0;
		rx_sh     = '0;
		dly       = 0;
		held_func = 1'b0;
		held_reg  = '0;
		held_data = '0;
		err       = 1'b0;
		errors    = 0;
		res_cnt   = 0;
		cycles    = 0;
		tx_gap    = 0;
		rx_gap    = 0;
		rx_hold   = 0;
		hold_reqs = 0;
		holds_served = 0;
		tx_quiet  = 1'b0;
		rx_quiet  = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: idle ticks, then the first slots of a write at the default
		// period; the rest of the write runs at a short period
		queue_req(1'b0, FUNC_READ, 8'hFF, 8'hFF, 1'b1);
		queue_req(1'b0, FUNC_WRITE, 8'h00, 8'h00, 1'b0);
		queue_req(1'b1, FUNC_WRITE, 8'hFF, 8'h00, 1'b0);
		queue_ticks(260, 0, 0);
		wait_drained();
		write_cfg(DEV_ID_RESET, 16'd1);
		settle(0);

		// zero half period runs as one tick; NACK on every ack slot
		write_cfg(8'h00, 16'h0000);
		queue_req(1'b1, FUNC_WRITE, 8'h00, 8'hFF, 1'b1);
		settle(100);
		// read with requests held high while busy
		queue_req(1'b1, FUNC_READ, 8'hA5, 8'h5A, 1'b1);
		queue_ticks(120, 100, 50);
		settle(50);

		// read keeps the error flag, a clean write clears it
		write_cfg(8'hFF, 16'd1);
		queue_req(1'b1, FUNC_READ, 8'h00, 8'h00, 1'b1);
		settle(100);
		queue_req(1'b1, FUNC_WRITE, 8'h3C, 8'hC3, 1'b0);
		settle(0);

		// random traffic over several settings
		for (int p = 0; p < 6; p++) begin
			case (p)
				0:       half = 1;
				1:       half = 2;
				2:       half = 3;
				4:       half = 5;
				default: half = $urandom_range(1, 4);
			endcase
			dev = (p == 1) ? 8'h00 : (p == 2) ? 8'hFF : 8'($urandom);
			write_cfg(dev, 16'(half));
			tx_quiet = (p == 3);
			rx_quiet = (p == 4);
			req_pct  = $urandom_range(20, 90);
			sda_pct  = (p == 0) ? 0 : (p == 5) ? 100 : $urandom_range(5, 95);
			queue_ticks(90, req_pct, sda_pct);
			if (p == 2)
				hold_reqs++;
			settle(sda_pct);
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;

		// longest slot: only the start of a write fits in the run
		write_cfg(8'($urandom), 16'hFFFF);
		queue_req(1'b1, FUNC_WRITE, 8'($urandom), 8'($urandom), 1'b0);
		queue_ticks(100, 50, 50);
		wait_drained();

		repeat (8) @(posedge clk);
		if (errors == 0 && bus_exp_q.size() == 0) begin
			$display("tb_sccb_register_master_top passed");
		end else begin
			$display("tb_sccb_register_master_top failed");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/sccb_pkg.sv
rtl/sccb_req_if.sv
rtl/sccb_res_if.sv
rtl/sccb_core.sv
rtl/sccb_register_master_top.sv
test/tb_sccb_register_master_top.sv
